// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module stress_chk.
// Each one samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/stress_pkg.sv -----
`timescale 1ns / 1ps

package stress_pkg;

	// Field widths.
	localparam int SCORE_W  = 17;
	localparam int DIV_W    = 18;
	localparam int PROD_W   = 32;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 72;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int NUM_CH   = 3;

	// Pipeline layout: one input stage, one stage per quotient bit, clamp,
	// multiply and output.
	localparam int DIV_STEPS  = 17;
	localparam int ST_PRE     = 0;
	localparam int ST_CLAMP   = DIV_STEPS + 1;
	localparam int ST_MUL     = DIV_STEPS + 2;
	localparam int ST_OUT     = DIV_STEPS + 3;
	localparam int NUM_STAGES = DIV_STEPS + 4;

	// Score channels.
	localparam int CH_EDA = 0;
	localparam int CH_HRV = 1;
	localparam int CH_HR  = 2;

	// Q16 one and the weights of the stress score.
	localparam logic [SCORE_W-1:0] Q_ONE = 17'd65536;
	localparam logic [14:0] W_EDA = 15'd26214;
	localparam logic [14:0] W_HRV = 15'd22938;
	localparam logic [14:0] W_HR  = 15'd16384;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_BASE_SCR = 2'd0;
	localparam logic [1:0] REG_BASE_HRV = 2'd1;
	localparam logic [1:0] REG_BASE_HR  = 2'd2;

	// One channel of the fractional divider: quotient = floor(n * 2^17 / den).
	typedef struct packed {
		logic [DIV_W-1:0]   rem;
		logic [DIV_W-1:0]   den;
		logic [SCORE_W-1:0] quo;
		logic               sat;
	} div_ch_t;

	typedef struct packed {
		div_ch_t [NUM_CH-1:0] ch;
		logic                 invalid;
	} div_t;

	typedef struct packed {
		logic [NUM_CH-1:0][SCORE_W-1:0] score;
		logic                           invalid;
	} score_t;

	typedef struct packed {
		logic [NUM_CH-1:0][PROD_W-1:0] prod;
		logic [NUM_CH-1:0][SCORE_W-1:0] score;
		logic                           invalid;
	} prod_t;

	// One restoring step: doubles the remainder and produces one quotient bit.
	function automatic div_ch_t div_step(div_ch_t c);
		div_ch_t           r;
		logic [DIV_W:0]    rem2;
		r = c;
		rem2 = {c.rem, 1'b0};
		if (rem2 >= {1'b0, c.den}) begin
			r.rem = DIV_W'(rem2 - {1'b0, c.den});
			r.quo = {c.quo[SCORE_W-2:0], 1'b1};
		end else begin
			r.rem = rem2[DIV_W-1:0];
			r.quo = {c.quo[SCORE_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ----- rtl/autonomic_stress_score.sv -----
`timescale 1ns / 1ps

// Autonomic stress score.
// Input stream s_*: one item per record, tdata = scr_rate_now, hrv_now,
// heart_rate_now from the lowest bit up. Output stream m_*: one item per
// input item, tdata = stress_score, eda_score, hrv_score, hr_score, tuser =
// baseline_invalid. All scores are Q16 fractions clamped to 0..65536.
// The three baselines are written over the APB port (0x0 skin response,
// 0x4 variability, 0x8 heart rate); the user must write them only while no
// item is in flight, which the block itself does not enforce.
// There are 21 register stages and the first is loaded at the accepting
// edge: one input stage, 17 divider stages (one quotient bit per stage for
// all three scores at once), a clamp stage, a multiply stage and the output
// register. Throughput is one item per cycle when the receiver does not stall.
// Every stage moves on when the stage after it is empty or moving, so a
// stalled receiver fills empty stages first and input stays open until
// the pipeline is full; nothing is dropped or repeated.
// Reset clears all valid bits and the three baselines to zero.
module autonomic_stress_score
	import stress_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Input items
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // scr_rate_now, hrv_now, heart_rate_now
	// Result items
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // stress_score, eda_score, hrv_score, hr_score, zero pad
	output logic              m_tuser   // baseline_invalid
);

	logic [15:0] base_scr_rate_q;
	logic [15:0] base_hrv_q;
	logic [7:0]  base_heart_rate_q;

	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] adv;

	div_t pre_nx;
	div_t pre_s1;
	div_t div_in [DIV_STEPS];
	div_t div_nx [DIV_STEPS];
	div_t div_s  [DIV_STEPS];
	score_t score_nx;
	score_t score_s19;
	prod_t  prod_s20;
	logic [SCORE_W+PROD_W-1:0] sum;
	logic [SCORE_W-1:0] stress_q;
	score_t out_q;

	logic [15:0] scr_rate_now;
	logic [15:0] hrv_now;
	logic [7:0]  heart_rate_now;
	logic [15:0] eda_d;
	logic [15:0] hrv_d;
	logic [7:0]  hr_d;
	logic        invalid;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_scr_rate_q   <= '0;
			base_hrv_q        <= '0;
			base_heart_rate_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_BASE_SCR: base_scr_rate_q <= pwdata[15:0];
				REG_BASE_HRV: base_hrv_q <= pwdata[15:0];
				REG_BASE_HR: base_heart_rate_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BASE_SCR: prdata = DATA_W'(base_scr_rate_q);
			REG_BASE_HRV: prdata = DATA_W'(base_hrv_q);
			REG_BASE_HR: prdata = DATA_W'(base_heart_rate_q);
			default: prdata = '0;
		endcase
	end

	// Stage handshake: a stage takes new data when it is empty or drains.
	always_comb begin
		adv[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || m_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			adv[i] = !stage_vld_q[i] || adv[i+1];
		end
	end

	assign s_tready = adv[ST_PRE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[ST_PRE]) begin
				stage_vld_q[ST_PRE] <= s_tvalid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (adv[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	// Input stage: deviations, divider operands and the saturation test.
	// Each score becomes floor(n * 2^17 / den) with n < den unless saturated.
	assign scr_rate_now   = s_tdata[15:0];
	assign hrv_now        = s_tdata[31:16];
	assign heart_rate_now = s_tdata[39:32];
	assign invalid = (base_scr_rate_q == '0) || (base_hrv_q == '0)
		|| (base_heart_rate_q == '0);
	assign eda_d = (scr_rate_now > base_scr_rate_q) ? scr_rate_now - base_scr_rate_q : '0;
	assign hrv_d = (base_hrv_q > hrv_now) ? base_hrv_q - hrv_now : '0;
	assign hr_d  = (heart_rate_now > base_heart_rate_q)
		? heart_rate_now - base_heart_rate_q : '0;

	always_comb begin
		pre_nx = '0;
		pre_nx.invalid = invalid;
		// Skin response: d * 2^15 / base, written as d * 2^17 / (4 * base).
		pre_nx.ch[CH_EDA].rem = DIV_W'(eda_d);
		pre_nx.ch[CH_EDA].den = {base_scr_rate_q, 2'b00};
		// Variability: 2 * d * 2^16 / base.
		pre_nx.ch[CH_HRV].rem = DIV_W'(hrv_d);
		pre_nx.ch[CH_HRV].den = DIV_W'(base_hrv_q);
		// Heart rate: 10 * d * 2^16 / (3 * base) = 5 * d * 2^17 / (3 * base).
		pre_nx.ch[CH_HR].rem = DIV_W'({hr_d, 2'b00}) + DIV_W'(hr_d);
		pre_nx.ch[CH_HR].den = DIV_W'({base_heart_rate_q, 1'b0})
			+ DIV_W'(base_heart_rate_q);
		for (int c = 0; c < NUM_CH; c++) begin
			pre_nx.ch[c].sat = !invalid && (pre_nx.ch[c].rem >= pre_nx.ch[c].den);
			if (invalid) begin
				pre_nx.ch[c].rem = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_PRE]) begin
			pre_s1 <= pre_nx;
		end
	end

	// Divider stages: one quotient bit per stage for each channel.
	always_comb begin
		div_in[0] = pre_s1;
		for (int j = 1; j < DIV_STEPS; j++) begin
			div_in[j] = div_s[j-1];
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			div_nx[j] = div_in[j];
			for (int c = 0; c < NUM_CH; c++) begin
				div_nx[j].ch[c] = div_step(div_in[j].ch[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (adv[ST_PRE+1+j]) begin
				div_s[j] <= div_nx[j];
			end
		end
	end

	// Clamp stage: saturate to one and zero everything on a bad baseline.
	always_comb begin
		score_nx.invalid = div_s[DIV_STEPS-1].invalid;
		for (int c = 0; c < NUM_CH; c++) begin
			if (div_s[DIV_STEPS-1].invalid) begin
				score_nx.score[c] = '0;
			end else if (div_s[DIV_STEPS-1].ch[c].sat
				|| (div_s[DIV_STEPS-1].ch[c].quo > Q_ONE)) begin
				score_nx.score[c] = Q_ONE;
			end else begin
				score_nx.score[c] = div_s[DIV_STEPS-1].ch[c].quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_CLAMP]) begin
			score_s19 <= score_nx;
		end
	end

	// Multiply stage: weight each component.
	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			prod_s20.prod[CH_EDA] <= PROD_W'(score_s19.score[CH_EDA]) * PROD_W'(W_EDA);
			prod_s20.prod[CH_HRV] <= PROD_W'(score_s19.score[CH_HRV]) * PROD_W'(W_HRV);
			prod_s20.prod[CH_HR]  <= PROD_W'(score_s19.score[CH_HR]) * PROD_W'(W_HR);
			prod_s20.score   <= score_s19.score;
			prod_s20.invalid <= score_s19.invalid;
		end
	end

	// Output stage: weighted sum, truncated by 16 bits.
	assign sum = (SCORE_W+PROD_W)'(prod_s20.prod[CH_EDA])
		+ (SCORE_W+PROD_W)'(prod_s20.prod[CH_HRV])
		+ (SCORE_W+PROD_W)'(prod_s20.prod[CH_HR]);

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			stress_q <= sum[16 +: SCORE_W];
			out_q    <= '{score: prod_s20.score, invalid: prod_s20.invalid};
		end
	end

	assign m_tvalid = stage_vld_q[ST_OUT];
	assign m_tuser  = out_q.invalid;
	assign m_tdata  = {4'b0000, out_q.score[CH_HR], out_q.score[CH_HRV],
		out_q.score[CH_EDA], stress_q};

endmodule

// ----- rtl/stress_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the stress score block.
module stress_chk
	import stress_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// A stalled result holds its value.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// With nothing waiting at the output the pipeline cannot be full.
	`ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input closed with empty output")

	// No score exceeds one in Q16.
	`ASSERT_SAME(a_score_range, m_tvalid, (m_tdata[16:0] <= Q_ONE) && (m_tdata[33:17] <= Q_ONE) && (m_tdata[50:34] <= Q_ONE) && (m_tdata[67:51] <= Q_ONE), "score above one")

	// A bad baseline zeroes every score.
	`ASSERT_SAME(a_invalid_zero, m_tvalid && m_tuser, m_tdata == '0, "scores not zero on bad baseline")

endmodule

bind autonomic_stress_score stress_chk u_stress_chk (.*);

// ----- test/tb_autonomic_stress_score.sv -----
`timescale 1ns / 1ps

module tb_autonomic_stress_score;
	import stress_pkg::*;

	// Register slot past the end of the register map; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Cycles with no handshake on any port before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Cycles to wait after the last expected result before the verdict.
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [SCORE_W-1:0] stress;
		logic [SCORE_W-1:0] eda;
		logic [SCORE_W-1:0] hrv;
		logic [SCORE_W-1:0] hr;
		logic               invalid;
	} scores_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;  // scr_rate_now, hrv_now, heart_rate_now
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;  // stress_score, eda_score, hrv_score, hr_score, zero pad
	logic              m_tuser;  // baseline_invalid

	// Baselines as the block should hold them.
	logic [15:0] base_scr;
	logic [15:0] base_hrv;
	logic [7:0]  base_hr;

	scores_t expected_scores[$];
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	autonomic_stress_score u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Score for a value that rises above lo:
	// floor(num_scale * 65536 * (hi - lo) / (den_scale * base)), clamped to 1.0.
	function automatic logic [SCORE_W-1:0] rise_score(input logic [15:0] hi,
			input logic [15:0] lo, input logic [15:0] base,
			input logic [3:0] num_scale, input logic [3:0] den_scale);
		logic [63:0] quo;
		if (hi <= lo) begin
			return '0;
		end
		quo = (64'(hi - lo) * 64'(num_scale) * 64'd65536)
			/ (64'(base) * 64'(den_scale));
		return (quo > 64'd65536) ? 17'd65536 : quo[SCORE_W-1:0];
	endfunction

	function automatic scores_t predict_scores(input logic [15:0] scr,
			input logic [15:0] hrv, input logic [7:0] hr);
		scores_t     res;
		logic [63:0] total;
		res = '0;
		if (base_scr == 0 || base_hrv == 0 || base_hr == 0) begin
			res.invalid = 1'b1;
			return res;
		end
		res.eda = rise_score(scr, base_scr, base_scr, 4'd1, 4'd2);
		res.hrv = rise_score(base_hrv, hrv, base_hrv, 4'd2, 4'd1);
		res.hr = rise_score({8'd0, hr}, {8'd0, base_hr}, {8'd0, base_hr}, 4'd10, 4'd3);
		total = (64'd26214 * 64'(res.eda) + 64'd22938 * 64'(res.hrv)
			+ 64'd16384 * 64'(res.hr)) >> 16;
		res.stress = total[SCORE_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every accepted result item with the oldest prediction.
	always @(posedge clk) begin
		scores_t got;
		scores_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.stress = m_tdata[16:0];
			got.eda = m_tdata[33:17];
			got.hrv = m_tdata[50:34];
			got.hr = m_tdata[67:51];
			got.invalid = m_tuser;
			if (expected_scores.size() == 0) begin
				report_mismatch("result item with no input item pending");
			end else begin
				want = expected_scores.pop_front();
				if (got.stress !== want.stress)
					report_mismatch($sformatf("stress_score %0d, want %0d",
						got.stress, want.stress));
				if (got.eda !== want.eda)
					report_mismatch($sformatf("eda_score %0d, want %0d",
						got.eda, want.eda));
				if (got.hrv !== want.hrv)
					report_mismatch($sformatf("hrv_score %0d, want %0d",
						got.hrv, want.hrv));
				if (got.hr !== want.hr)
					report_mismatch($sformatf("hr_score %0d, want %0d",
						got.hr, want.hr));
				if (got.invalid !== want.invalid)
					report_mismatch($sformatf("baseline_invalid %0b, want %0b",
						got.invalid, want.invalid));
			end
		end
	end

	// Abort when no port has moved anything for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_autonomic_stress_score NOT OK");
		$finish;
	end

	// Offer one vital-sign item, with random idle cycles ahead of it.
	task automatic send_vitals(input logic [15:0] scr, input logic [15:0] hrv,
			input logic [7:0] hr);
		scores_t want;
		want = predict_scores(scr, hrv, hr);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {hr, hrv, scr};
		do @(posedge clk); while (!s_tready);
		expected_scores.push_back(want);
	endtask

	// Stop offering items and wait for every result to come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_transfer(input logic write, input logic [1:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a baseline with junk in the unused upper bits; read back all but REG_UNUSED.
	task automatic write_baseline(input logic [1:0] idx, input logic [15:0] value);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] rdata;
		logic [DATA_W-1:0] kept;
		mask = (idx == REG_BASE_HR) ? 32'h0000_00FF : 32'h0000_FFFF;
		kept = 32'(value) & mask;
		apb_transfer(1'b1, idx, ($urandom() & ~mask) | kept, rdata);
		case (idx)
			REG_BASE_SCR: base_scr = kept[15:0];
			REG_BASE_HRV: base_hrv = kept[15:0];
			REG_BASE_HR:  base_hr = kept[7:0];
			default: ;
		endcase
		if (idx != REG_UNUSED) begin
			apb_transfer(1'b0, idx, '0, rdata);
			if (rdata !== kept)
				report_mismatch($sformatf("register %0d reads %h, want %h",
					idx, rdata, kept));
		end
	endtask

	task automatic set_baselines(input logic [15:0] scr, input logic [15:0] hrv,
			input logic [7:0] hr);
		drain_results();
		write_baseline(REG_BASE_SCR, scr);
		write_baseline(REG_BASE_HRV, hrv);
		write_baseline(REG_BASE_HR, {8'd0, hr});
	endtask

	// A zero in any baseline forces all scores to zero and raises the flag.
	task automatic test_zero_baseline();
		send_vitals(16'h0000, 16'h0000, 8'h00);
		send_vitals(16'hFFFF, 16'hFFFF, 8'hFF);
		set_baselines(16'd1000, 16'd2000, 8'd0);
		send_vitals(16'd3000, 16'd10, 8'd200);
		set_baselines(16'd0, 16'd2000, 8'd70);
		send_vitals(16'd3000, 16'd10, 8'd200);
		set_baselines(16'd1000, 16'd0, 8'd70);
		send_vitals(16'd3000, 16'd10, 8'd200);
	endtask

	// Calm side, exact baseline, mid range, saturation and the baseline extremes.
	task automatic test_directed_scores();
		set_baselines(16'd1000, 16'd2000, 8'd70);
		send_vitals(16'd1000, 16'd2000, 8'd70);
		send_vitals(16'h0000, 16'hFFFF, 8'h00);
		send_vitals(16'hFFFF, 16'h0000, 8'hFF);
		send_vitals(16'd1500, 16'd1500, 8'd80);
		send_vitals(16'd1001, 16'd1999, 8'd71);
		send_vitals(16'd2999, 16'd1001, 8'd91);
		set_baselines(16'd1, 16'd1, 8'd1);
		send_vitals(16'd0, 16'd0, 8'd0);
		send_vitals(16'd2, 16'd1, 8'd2);
		send_vitals(16'hFFFF, 16'hFFFF, 8'hFF);
		set_baselines(16'hFFFF, 16'hFFFF, 8'hFF);
		send_vitals(16'hFFFF, 16'hFFFF, 8'hFF);
		send_vitals(16'h0000, 16'h0000, 8'h00);
		send_vitals(16'hFFFF, 16'h8000, 8'hFF);
	endtask

	// A write past the last register must leave every baseline alone.
	task automatic test_unused_register();
		set_baselines(16'd500, 16'd800, 8'd60);
		write_baseline(REG_UNUSED, 16'hFFFF);
		send_vitals(16'd700, 16'd600, 8'd75);
		send_vitals(16'hA5A5, 16'h5A5A, 8'hA5);
	endtask

	function automatic logic [15:0] random_baseline(input logic [15:0] max_val);
		int pick;
		pick = $urandom_range(19);
		case (pick)
			0: return 16'd0;
			1: return 16'd1;
			2: return max_val;
			3, 4, 5: return 16'($urandom_range(31, 1));
			6, 7, 8: return 16'($urandom_range((max_val < 120) ? max_val : 120, 1));
			default: return 16'($urandom_range(max_val, 1));
		endcase
	endfunction

	// Mostly values around the baseline, where the scores are neither zero nor full.
	function automatic logic [15:0] random_reading(input logic [15:0] base,
			input logic [15:0] max_val);
		int hi;
		if ($urandom_range(9) < 4)
			return 16'($urandom_range(max_val));
		hi = 3 * int'(base) + 2;
		if (hi > int'(max_val))
			hi = max_val;
		return 16'($urandom_range(hi));
	endfunction

	task automatic test_random_traffic(input int groups, input int items_per_group);
		logic [15:0] hr_val;
		for (int g = 0; g < groups; g++) begin
			hr_val = random_baseline(16'd255);
			set_baselines(random_baseline(16'hFFFF), random_baseline(16'hFFFF), hr_val[7:0]);
			repeat (items_per_group) begin
				hr_val = random_reading({8'd0, base_hr}, 16'd255);
				send_vitals(random_reading(base_scr, 16'hFFFF),
					random_reading(base_hrv, 16'hFFFF), hr_val[7:0]);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		base_scr = '0;
		base_hrv = '0;
		base_hr = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 10;
		recv_stall_pct = 10;
		test_zero_baseline();
		test_directed_scores();
		test_unused_register();

		send_idle_pct = 25;
		recv_stall_pct = 84;
		test_random_traffic(4, 110);
		send_idle_pct = 84;
		recv_stall_pct = 25;
		test_random_traffic(4, 110);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(4, 110);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_autonomic_stress_score OK");
		else
			$display("tb_autonomic_stress_score NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/stress_pkg.sv
rtl/autonomic_stress_score.sv
rtl/stress_chk.sv
test/tb_autonomic_stress_score.sv
